// ===== hdl/tdvt_pkg.sv =====
// Package for the touch drag value throttle: field widths, opcodes,
// register indexes and the sequencer state type.
// No dependencies.
package tdvt_pkg;

  localparam int OPCODE_W   = 2;
  localparam int TOUCH_Y_W  = 10;
  localparam int NOW_W      = 32;
  localparam int VALUE_W    = 10;
  localparam int WORD_W     = 16;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TOUCH   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_POLL    = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MIN_VALUE   = 3'd0,
    REG_MAX_VALUE   = 3'd1,
    REG_UNIT_TENTHS = 3'd2,
    REG_INTERVAL    = 3'd3,
    REG_START_VALUE = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_CLAMP,
    ST_ROUND,
    ST_FINISH
  } state_t;

  // control lines from the sequencer
  typedef struct packed {
    logic in_ready;
    logic div_start;
    logic out_load;
  } seq_ctrl_t;

endpackage

// ===== hdl/tdvt_if.sv =====
// Channel interfaces: touch request, result and configuration write.
// Depends on tdvt_pkg.
interface tdvt_req_if;
  logic                           valid;
  logic                           ready;
  logic [tdvt_pkg::OPCODE_W-1:0]  opcode;
  logic [tdvt_pkg::TOUCH_Y_W-1:0] touch_y;
  logic                           landed;
  logic [tdvt_pkg::NOW_W-1:0]     now_ms;
  modport source (output valid, opcode, touch_y, landed, now_ms, input ready);
  modport sink   (input valid, opcode, touch_y, landed, now_ms, output ready);
endinterface

interface tdvt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         report_ready;
  logic [tdvt_pkg::VALUE_W-1:0] reported_value;
  logic [tdvt_pkg::VALUE_W-1:0] current_value;
  logic                         dragging;
  modport source (output valid, report_ready, reported_value, current_value, dragging,
                  input ready);
  modport sink   (input valid, report_ready, reported_value, current_value, dragging,
                  output ready);
endinterface

interface tdvt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tdvt_pkg::CFG_ADDR_W-1:0] addr;
  logic [tdvt_pkg::WORD_W-1:0]     data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== hdl/tdvt_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Standalone; used by touch_drag_value_throttle_core.
module tdvt_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             ge;

  always_comb begin
    trial     = {rem, quot[NUM_W-1]};
    ge        = trial >= {1'b0, den};
    trial_sub = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
    end else if (busy) begin
      rem  <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], ge};
    end
  end

endmodule

// ===== hdl/touch_drag_value_throttle_core.sv =====
// Channel  Dir   Handshake     Payload
// req      in    valid/ready   opcode, touch_y, landed, now_ms
// rsp      out   valid/ready   report_ready, reported_value, current_value, dragging
// cfg      in    valid/ready   addr, data (always ready)
//
// A landing touch or a touch during a drag runs through the bit-serial divider and then
// the clamp and round states; release, poll, idle touch and no-op go straight to finish.
// One request is in flight at a time; req.ready is high only in the idle state.
// A finished result waits in the output register; a stalled rsp holds the
// sequencer at its last state. Reset is synchronous and loads the register defaults.
// Depends on tdvt_pkg, tdvt_if and tdvt_div.
module touch_drag_value_throttle_core #(
  parameter int ROW_BITS      = 10,
  parameter int FRACTION_BITS = 8
) (
  input  logic     clk,
  input  logic     rst,
  tdvt_req_if.sink   req,
  tdvt_rsp_if.source rsp,
  tdvt_cfg_if.sink   cfg
);

  localparam int VW = tdvt_pkg::VALUE_W;
  localparam int PW = VW + FRACTION_BITS;
  localparam int NW = ROW_BITS + 4 + FRACTION_BITS;
  localparam int SW = ((NW > PW) ? NW : PW) + 2;
  localparam logic [PW:0] HALF = (PW + 1)'(1) << (FRACTION_BITS - 1);

  // configuration
  logic [VW-1:0]                  min_value;
  logic [VW-1:0]                  max_value;
  logic [tdvt_pkg::WORD_W-1:0]    unit_tenths;
  logic [tdvt_pkg::WORD_W-1:0]    report_interval_ms;
  logic [VW-1:0]                  start_value;

  // slider state
  logic [PW-1:0]                  position;
  logic [PW-1:0]                  grab_position;
  logic [ROW_BITS-1:0]            grab_row;
  logic [VW-1:0]                  shown_value;
  logic                           report_pending;
  logic                           drag_active;
  logic [tdvt_pkg::NOW_W-1:0]     last_report_time;
  logic                           quot_neg;
  logic                           res_report;
  logic [VW-1:0]                  res_value;

  tdvt_pkg::state_t    state, state_next;
  tdvt_pkg::seq_ctrl_t ctrl;
  tdvt_pkg::opcode_t   op;

  logic                accept;
  logic                needs_div;
  logic [ROW_BITS-1:0] row;
  logic [ROW_BITS-1:0] grab_eff;
  logic                row_neg;
  logic [ROW_BITS-1:0] diff;
  logic [ROW_BITS+3:0] diff10;
  logic [NW-1:0]       num;
  logic [tdvt_pkg::WORD_W-1:0] den;
  logic [NW-1:0]       quot;
  logic                div_done;
  logic [tdvt_pkg::NOW_W-1:0] elapsed;
  logic                poll_ok;

  logic signed [SW-1:0] gp_s, q_s, p_sum, lo_s, hi_s, p_lo, p_cl;
  logic [PW:0]          rnd;
  logic [VW-1:0]        rnd_value;

  logic          out_valid;
  logic          out_report;
  logic [VW-1:0] out_reported;
  logic [VW-1:0] out_current;
  logic          out_dragging;

  assign op        = tdvt_pkg::opcode_t'(req.opcode);
  assign accept    = req.valid && ctrl.in_ready;
  assign needs_div = (op == tdvt_pkg::OP_TOUCH) && (req.landed || drag_active);
  assign req.ready = ctrl.in_ready;
  assign cfg.ready = 1'b1;

  // finger up (smaller row) moves the position up
  always_comb begin
    row      = ROW_BITS'(req.touch_y);
    grab_eff = req.landed ? row : grab_row;
    row_neg  = row > grab_eff;
    diff     = row_neg ? (row - grab_eff) : (grab_eff - row);
    diff10   = {1'b0, diff, 3'b000} + {3'b000, diff, 1'b0};
    num      = {diff10, {FRACTION_BITS{1'b0}}};
    den      = (unit_tenths == '0) ? tdvt_pkg::WORD_W'(1) : unit_tenths;
  end

  always_comb begin
    elapsed = req.now_ms - last_report_time;
    poll_ok = report_pending &&
              !(drag_active && (elapsed < {16'b0, report_interval_ms}));
  end

  tdvt_div #(
    .NUM_W (NW),
    .DEN_W (tdvt_pkg::WORD_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.div_start),
    .num   (num),
    .den   (den),
    .quot  (quot),
    .done  (div_done)
  );

  // clamp: raise to min first, then lower to max
  always_comb begin
    gp_s  = $signed(SW'(grab_position));
    q_s   = $signed(SW'(quot));
    p_sum = quot_neg ? (gp_s - q_s) : (gp_s + q_s);
    lo_s  = $signed(SW'({min_value, {FRACTION_BITS{1'b0}}}));
    hi_s  = $signed(SW'({max_value, {FRACTION_BITS{1'b0}}}));
    p_lo  = (p_sum < lo_s) ? lo_s : p_sum;
    p_cl  = (p_lo > hi_s) ? hi_s : p_lo;
  end

  always_comb begin
    rnd       = {1'b0, position} + HALF;
    rnd_value = rnd[FRACTION_BITS+VW-1:FRACTION_BITS];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tdvt_pkg::ST_IDLE: begin
        if (accept) state_next = needs_div ? tdvt_pkg::ST_DIVIDE : tdvt_pkg::ST_FINISH;
      end
      tdvt_pkg::ST_DIVIDE: begin
        if (div_done) state_next = tdvt_pkg::ST_CLAMP;
      end
      tdvt_pkg::ST_CLAMP:  state_next = tdvt_pkg::ST_ROUND;
      tdvt_pkg::ST_ROUND:  state_next = tdvt_pkg::ST_FINISH;
      tdvt_pkg::ST_FINISH: begin
        if (!out_valid || rsp.ready) state_next = tdvt_pkg::ST_IDLE;
      end
      default: state_next = tdvt_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    case (state)
      tdvt_pkg::ST_IDLE: begin
        ctrl.in_ready  = 1'b1;
        ctrl.div_start = req.valid && needs_div;
      end
      tdvt_pkg::ST_FINISH: ctrl.out_load = !out_valid || rsp.ready;
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tdvt_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_value          <= VW'(0);
      max_value          <= VW'(100);
      unit_tenths        <= tdvt_pkg::WORD_W'(100);
      report_interval_ms <= tdvt_pkg::WORD_W'(40);
      start_value        <= VW'(0);
      position           <= '0;
      grab_position      <= '0;
      grab_row           <= '0;
      shown_value        <= '0;
      report_pending     <= 1'b0;
      drag_active        <= 1'b0;
      last_report_time   <= '0;
    end else begin
      if (cfg.valid) begin
        case (tdvt_pkg::cfg_index_t'(cfg.addr))
          tdvt_pkg::REG_MIN_VALUE:   min_value <= cfg.data[VW-1:0];
          tdvt_pkg::REG_MAX_VALUE:   max_value <= cfg.data[VW-1:0];
          tdvt_pkg::REG_UNIT_TENTHS: unit_tenths <= cfg.data;
          tdvt_pkg::REG_INTERVAL:    report_interval_ms <= cfg.data;
          tdvt_pkg::REG_START_VALUE: begin
            start_value <= cfg.data[VW-1:0];
            position    <= {cfg.data[VW-1:0], {FRACTION_BITS{1'b0}}};
            shown_value <= cfg.data[VW-1:0];
          end
          default: ;
        endcase
      end
      if (accept) begin
        case (op)
          tdvt_pkg::OP_TOUCH: begin
            if (req.landed) begin
              drag_active   <= 1'b1;
              grab_row      <= row;
              grab_position <= position;
            end
          end
          tdvt_pkg::OP_RELEASE: begin
            if (drag_active) begin
              drag_active      <= 1'b0;
              last_report_time <= '0;
            end
          end
          tdvt_pkg::OP_POLL: begin
            if (poll_ok) begin
              report_pending   <= 1'b0;
              last_report_time <= req.now_ms;
            end
          end
          default: ;
        endcase
      end
      if (state == tdvt_pkg::ST_CLAMP) position <= p_cl[PW-1:0];
      if (state == tdvt_pkg::ST_ROUND && rnd_value != shown_value) begin
        shown_value    <= rnd_value;
        report_pending <= 1'b1;
      end
    end
  end

  // per-request scratch
  always_ff @(posedge clk) begin
    if (accept) begin
      quot_neg   <= row_neg;
      res_report <= (op == tdvt_pkg::OP_POLL) && poll_ok;
      res_value  <= ((op == tdvt_pkg::OP_POLL) && poll_ok) ? shown_value : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_report   <= res_report;
      out_reported <= res_value;
      out_current  <= shown_value;
      out_dragging <= drag_active;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.report_ready   = out_report;
  assign rsp.reported_value = out_reported;
  assign rsp.current_value  = out_current;
  assign rsp.dragging       = out_dragging;

endmodule

// ===== hdl/tdvt_checker.sv =====
// Port-level checks for touch_drag_value_throttle_core, attached by bind.
// Depends on tdvt_pkg.
module tdvt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         report_ready,
  input logic [tdvt_pkg::VALUE_W-1:0] reported_value,
  input logic [tdvt_pkg::VALUE_W-1:0] current_value,
  input logic                         dragging
);

  // one request at a time: busy right after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one in flight");

  a_no_report_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !report_ready |-> reported_value == '0)
    else $error("reported_value nonzero without report");

  // a poll never moves the value, so the report matches it
  a_report_current: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && report_ready |-> reported_value == current_value)
    else $error("reported value differs from current value");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(reported_value) &&
      $stable(current_value) && $stable(report_ready) && $stable(dragging))
    else $error("stalled result changed");

endmodule

bind touch_drag_value_throttle_core tdvt_checker u_tdvt_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .report_ready   (rsp.report_ready),
  .reported_value (rsp.reported_value),
  .current_value  (rsp.current_value),
  .dragging       (rsp.dragging)
);

// ===== sim/tb_touch_drag_value_throttle_core.sv =====
// Testbench for touch_drag_value_throttle_core: drives drag, release, poll and no-op requests
// and register writes, and checks each response against an in-bench slider predictor.
// Depends on tdvt_pkg, tdvt_if and the core RTL.
module tb_touch_drag_value_throttle_core;

  localparam int FRAC          = 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 40;
  localparam int YW            = tdvt_pkg::TOUCH_Y_W;
  localparam int VLW           = tdvt_pkg::VALUE_W;
  localparam int WW            = tdvt_pkg::WORD_W;
  localparam int TW            = tdvt_pkg::NOW_W;

  typedef struct packed {
    logic           rdy;
    logic [VLW-1:0] reported;
    logic [VLW-1:0] value;
    logic           drag;
  } slider_status_t;

  logic clk;
  logic rst;

  tdvt_req_if req_ch ();
  tdvt_rsp_if rsp_ch ();
  tdvt_cfg_if cfg_ch ();

  touch_drag_value_throttle_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // predictor copy of the registers
  logic [VLW-1:0] lo_val;
  logic [VLW-1:0] hi_val;
  logic [WW-1:0]  unit_div;
  logic [WW-1:0]  min_gap_ms;
  logic [VLW-1:0] preset_val;

  // predictor copy of the slider state
  logic [17:0]    pos_q8;
  logic [17:0]    grab_pos;
  logic [YW-1:0]  grab_y;
  logic [VLW-1:0] shown;
  logic           pending;
  logic           drag_on;
  logic [TW-1:0]  last_report;

  slider_status_t expected_status_q[$];
  slider_status_t head_status;

  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned cfg_writes;
  int unsigned error_count;
  int unsigned hold_left;
  int unsigned stall_left;
  bit          src_idle_on;
  bit          sink_idle_on;
  bit          idle_allowed;
  logic [TW-1:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void slider_reset();
    lo_val      = 10'd0;
    hi_val      = 10'd100;
    unit_div    = 16'd100;
    min_gap_ms  = 16'd40;
    preset_val  = 10'd0;
    pos_q8      = '0;
    shown       = '0;
    grab_pos    = '0;
    grab_y      = '0;
    pending     = 1'b0;
    drag_on     = 1'b0;
    last_report = '0;
  endfunction

  function automatic void cfg_apply(tdvt_pkg::cfg_index_t idx, logic [WW-1:0] d);
    case (idx)
      tdvt_pkg::REG_MIN_VALUE:   lo_val = d[VLW-1:0];
      tdvt_pkg::REG_MAX_VALUE:   hi_val = d[VLW-1:0];
      tdvt_pkg::REG_UNIT_TENTHS: unit_div = d;
      tdvt_pkg::REG_INTERVAL:    min_gap_ms = d;
      tdvt_pkg::REG_START_VALUE: begin
        preset_val = d[VLW-1:0];
        pos_q8     = 18'(preset_val) << FRAC;
        shown      = preset_val;
      end
      default: ;
    endcase
  endfunction

  function automatic slider_status_t slider_step(tdvt_pkg::opcode_t op, logic [YW-1:0] y,
                                                 logic land, logic [TW-1:0] now);
    slider_status_t r;
    longint diff, mag, div, p, lo, hi;
    logic [VLW-1:0] v;
    logic [TW-1:0] since;
    r = '0;
    case (op)
      tdvt_pkg::OP_TOUCH: begin
        if (land) begin
          drag_on  = 1'b1;
          grab_y   = y;
          grab_pos = pos_q8;
        end
        if (drag_on) begin
          div  = (unit_div == 0) ? 1 : longint'(unit_div);
          diff = longint'(grab_y) - longint'(y);
          // finger up (smaller row) raises the value; magnitude truncates toward zero
          mag  = ((diff < 0 ? -diff : diff) * 10 * (1 << FRAC)) / div;
          p    = longint'(grab_pos) + (diff < 0 ? -mag : mag);
          lo   = longint'(lo_val) * (1 << FRAC);
          hi   = longint'(hi_val) * (1 << FRAC);
          if (p < lo) p = lo;
          if (p > hi) p = hi;
          pos_q8 = p[17:0];
          v = VLW'((p + (1 << (FRAC - 1))) >> FRAC);
          if (v != shown) begin
            shown   = v;
            pending = 1'b1;
          end
        end
      end
      tdvt_pkg::OP_RELEASE: begin
        if (drag_on) begin
          drag_on     = 1'b0;
          last_report = '0;
        end
      end
      tdvt_pkg::OP_POLL: begin
        since = now - last_report;
        if (pending && !(drag_on && since < TW'(min_gap_ms))) begin
          pending     = 1'b0;
          last_report = now;
          r.rdy       = 1'b1;
          r.reported  = shown;
        end
      end
      default: ;
    endcase
    r.value = shown;
    r.drag  = drag_on;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // response checker
  always @(posedge clk) begin
    if (rsp_ch.valid && rsp_ch.ready) begin
      if (expected_status_q.size() == 0) begin
        error_count++;
        $display("%0t: response with no request outstanding", $time);
      end else begin
        head_status = expected_status_q.pop_front();
        check_field("report_ready", 32'(head_status.rdy), 32'(rsp_ch.report_ready));
        check_field("reported_value", 32'(head_status.reported),
                    32'(rsp_ch.reported_value));
        check_field("current_value", 32'(head_status.value), 32'(rsp_ch.current_value));
        check_field("dragging", 32'(head_status.drag), 32'(rsp_ch.dragging));
        results_checked++;
      end
    end
  end

  // response side stalls: long hold first, then random bursts
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready = 1'b0;
        stall_left   = $urandom_range(0, 8);
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // watchdog: ends the run if nothing moves on any channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_request(tdvt_pkg::opcode_t op, logic [YW-1:0] y, logic land,
                              logic [TW-1:0] now);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    req_ch.valid   = 1'b1;
    req_ch.opcode  = op;
    req_ch.touch_y = y;
    req_ch.landed  = land;
    req_ch.now_ms  = now;
    do @(posedge clk); while (!req_ch.ready);
    expected_status_q.push_back(slider_step(op, y, land, now));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_until_drained();
    req_ch.valid = 1'b0;
    while (expected_status_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_register(tdvt_pkg::cfg_index_t idx, logic [WW-1:0] d);
    cfg_ch.valid = 1'b1;
    cfg_ch.addr  = idx;
    cfg_ch.data  = d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_apply(idx, d);
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_all(int mn, int mx, int unit, int gap, int start);
    wait_until_drained();
    set_register(tdvt_pkg::REG_MIN_VALUE, WW'(mn));
    set_register(tdvt_pkg::REG_MAX_VALUE, WW'(mx));
    set_register(tdvt_pkg::REG_UNIT_TENTHS, WW'(unit));
    set_register(tdvt_pkg::REG_INTERVAL, WW'(gap));
    set_register(tdvt_pkg::REG_START_VALUE, WW'(start));
  endtask

  function automatic logic [TW-1:0] tick();
    case ($urandom_range(0, 19))
      0:       clock_ms += $urandom();
      1, 2, 3: clock_ms += $urandom_range(30, 200);
      default: clock_ms += $urandom_range(0, 25);
    endcase
    return clock_ms;
  endfunction

  function automatic int near_row(int base, int spread);
    int r;
    r = base + $urandom_range(0, 2 * spread) - spread;
    if (r < 0) r = 0;
    if (r > 1023) r = 1023;
    return r;
  endfunction

  function automatic logic [YW-1:0] any_row();
    return YW'($urandom_range(0, 1023));
  endfunction

  function automatic logic any_flag();
    return 1'($urandom_range(0, 1));
  endfunction

  // one well-formed drag: land, move and poll (now and then a re-land or no-op), mostly a release, then a poll
  task automatic drag_session();
    int base, spread, pick;
    base = $urandom_range(0, 1023);
    case ($urandom_range(0, 2))
      0:       spread = 6;
      1:       spread = 60;
      default: spread = 1023;
    endcase
    send_request(tdvt_pkg::OP_TOUCH, YW'(base), 1'b1, tick());
    repeat ($urandom_range(1, 14)) begin
      pick = $urandom_range(0, 19);
      if (pick < 11)
        send_request(tdvt_pkg::OP_TOUCH, YW'(near_row(base, spread)), 1'b0, tick());
      else if (pick == 11)
        send_request(tdvt_pkg::OP_TOUCH, YW'(near_row(base, spread)), 1'b1, tick());
      else if (pick < 19)
        send_request(tdvt_pkg::OP_POLL, any_row(), any_flag(), tick());
      else
        send_request(tdvt_pkg::OP_NOP, any_row(), any_flag(), tick());
    end
    if ($urandom_range(0, 9) != 0)
      send_request(tdvt_pkg::OP_RELEASE, any_row(), any_flag(), tick());
    send_request(tdvt_pkg::OP_POLL, any_row(), any_flag(), tick());
  endtask

  task automatic run_traffic(int n);
    int unsigned target;
    target = items_sent + n;
    while (items_sent < target) begin
      src_idle_on  = idle_allowed && ($urandom_range(0, 2) != 0);
      sink_idle_on = idle_allowed && ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 9) < 8)
        drag_session();
      else
        repeat ($urandom_range(1, 4))
          send_request(tdvt_pkg::opcode_t'($urandom_range(0, 3)), any_row(),
                       any_flag(), $urandom());
    end
  endtask

  task automatic test_directed_cases();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b1;
    send_request(tdvt_pkg::OP_POLL, 10'd0, 1'b0, 32'd0);
    send_request(tdvt_pkg::OP_TOUCH, 10'd500, 1'b0, 32'd1);       // no drag, ignored
    send_request(tdvt_pkg::OP_RELEASE, 10'd0, 1'b0, 32'd2);       // release while resting
    send_request(tdvt_pkg::OP_NOP, 10'd1023, 1'b1, 32'hFFFF_FFFF);
    send_request(tdvt_pkg::OP_TOUCH, 10'd1023, 1'b1, 32'd0);      // grab at bottom row
    send_request(tdvt_pkg::OP_TOUCH, 10'd0, 1'b0, 32'd3);         // full travel, clamps at max
    send_request(tdvt_pkg::OP_POLL, 10'd0, 1'b0, 32'd10);         // inside the interval
    send_request(tdvt_pkg::OP_POLL, 10'd0, 1'b0, 32'd50);
    send_request(tdvt_pkg::OP_TOUCH, 10'd1023, 1'b0, 32'd55);
    send_request(tdvt_pkg::OP_POLL, 10'd0, 1'b0, 32'd60);
    send_request(tdvt_pkg::OP_POLL, 10'd0, 1'b0, 32'hFFFF_FFFF);  // wrapping time
    send_request(tdvt_pkg::OP_TOUCH, 10'd1018, 1'b0, 32'd70);     // exactly half, rounds up
    send_request(tdvt_pkg::OP_TOUCH, 10'd1019, 1'b0, 32'd71);
    send_request(tdvt_pkg::OP_RELEASE, 10'd1023, 1'b1, 32'd72);
    send_request(tdvt_pkg::OP_POLL, 10'd0, 1'b0, 32'd5);          // after release: at once
    // unit zero, min above max, start value preload
    set_all(900, 50, 0, 40, 1000);
    send_request(tdvt_pkg::OP_POLL, 10'd0, 1'b0, 32'd6);
    send_request(tdvt_pkg::OP_TOUCH, 10'd0, 1'b1, 32'd7);
    send_request(tdvt_pkg::OP_TOUCH, 10'd1023, 1'b0, 32'd8);
    send_request(tdvt_pkg::OP_POLL, 10'd0, 1'b0, 32'hFFFF_FFFF);
    send_request(tdvt_pkg::OP_RELEASE, 10'd0, 1'b0, 32'd9);
    send_request(tdvt_pkg::OP_RELEASE, 10'd0, 1'b0, 32'd10);
    set_all(0, 1000, 65535, 65535, 0);
    send_request(tdvt_pkg::OP_TOUCH, 10'd512, 1'b1, 32'd0);
    send_request(tdvt_pkg::OP_TOUCH, 10'd0, 1'b0, 32'd1);
    send_request(tdvt_pkg::OP_POLL, 10'd0, 1'b0, 32'd65534);
    send_request(tdvt_pkg::OP_RELEASE, 10'd0, 1'b0, 32'd65535);
  endtask

  task automatic test_default_drags();
    set_all(0, 100, 100, 40, 0);
    run_traffic(200);
  endtask

  task automatic test_unit_extremes();
    set_all(0, 1000, 1, 40, 500);
    run_traffic(120);
    set_all(0, 1000, 65535, 40, 500);
    run_traffic(120);
    set_all(10, 90, 0, 40, 50);
    run_traffic(60);
  endtask

  task automatic test_range_extremes();
    set_all(0, 1000, 30, 40, 1000);
    run_traffic(120);
    set_all(999, 1000, 5, 20, 0);
    run_traffic(60);
    set_all(700, 200, 50, 40, 400);
    run_traffic(60);
    set_all(500, 500, 10, 40, 500);
    run_traffic(40);
  endtask

  task automatic test_interval_extremes();
    set_all(0, 1000, 40, 0, 300);
    run_traffic(100);
    set_all(0, 1000, 40, 65535, 300);
    clock_ms = 32'hFFFF_0000;
    run_traffic(100);
    set_all(0, 1000, 80, 40, 300);
    clock_ms = 32'hFFFF_FF00;
    run_traffic(100);
  endtask

  task automatic test_random_settings();
    int mn, mx;
    repeat (5) begin
      mn = $urandom_range(0, 999);
      mx = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1000) : $urandom_range(mn + 1, 1000);
      set_all(mn, mx,
              ($urandom_range(0, 1) != 0) ? $urandom_range(1, 300) : $urandom_range(0, 65535),
              ($urandom_range(0, 3) != 0) ? $urandom_range(0, 100) : $urandom_range(0, 65535),
              $urandom_range(0, 1000));
      clock_ms = $urandom();
      run_traffic(60);
    end
  endtask

  // hold the response side while requests keep coming, then let everything drain
  task automatic test_backpressure();
    int base;
    set_all(0, 1000, 20, 40, 500);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_left    = LONG_HOLD;
    base         = $urandom_range(100, 900);
    send_request(tdvt_pkg::OP_TOUCH, YW'(base), 1'b1, tick());
    repeat (10) send_request(tdvt_pkg::OP_TOUCH, YW'(near_row(base, 80)), 1'b0, tick());
    send_request(tdvt_pkg::OP_POLL, 10'd0, 1'b0, tick());
    wait_until_drained();
    run_traffic(30);
  endtask

  task automatic test_steady_stream();
    idle_allowed = 1'b0;
    set_all(0, 1000, 50, 30, 250);
    run_traffic(200);
  endtask

  initial begin
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.opcode  = tdvt_pkg::OP_NOP;
    req_ch.touch_y = '0;
    req_ch.landed  = 1'b0;
    req_ch.now_ms  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.addr    = tdvt_pkg::REG_MIN_VALUE;
    cfg_ch.data    = '0;
    items_sent      = 0;
    results_checked = 0;
    cfg_writes      = 0;
    error_count     = 0;
    hold_left       = 0;
    stall_left      = 0;
    src_idle_on     = 1'b0;
    sink_idle_on    = 1'b0;
    idle_allowed    = 1'b1;
    clock_ms        = $urandom();
    slider_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_default_drags();
    test_unit_extremes();
    test_range_extremes();
    test_interval_extremes();
    test_random_settings();
    test_backpressure();
    test_steady_stream();

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_status_q.size() != 0) begin
      error_count++;
      $display("%0t: %0d responses never arrived", $time, expected_status_q.size());
    end
    $display("Ran %0d touch/release/poll/no-op requests under %0d register writes,",
             items_sent, cfg_writes);
    $display("covering clamps, rounding, unit extremes, wrapping time, long stalls; %0d checked.",
             results_checked);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tdvt_pkg.sv
hdl/tdvt_if.sv
hdl/tdvt_div.sv
hdl/touch_drag_value_throttle_core.sv
hdl/tdvt_checker.sv
sim/tb_touch_drag_value_throttle_core.sv
